@@ rtl/core/bpu_pkg.sv @@
// ----------------------------------------------------------------------------
// bpu_pkg
// Shared types and constants of the BMP pixel unpacker.
// ----------------------------------------------------------------------------
package bpu_pkg;

  // Largest row length and row count the block ever addresses.
  localparam int MaxWidth   = 4096;
  localparam int MaxHeight  = 4096;
  localparam int WidthLimit  = (MaxWidth  < 4096) ? ((MaxWidth  < 1) ? 1 : MaxWidth)  : 4096;
  localparam int HeightLimit = (MaxHeight < 4096) ? ((MaxHeight < 1) ? 1 : MaxHeight) : 4096;

  localparam int DimW   = 13;  // width of the dimension registers
  localparam int PosW   = 12;  // column and row counters
  localparam int IndexW = 24;  // raster index
  localparam int ColorW = 24;  // palette color

  typedef enum logic [2:0] {
    DEPTH_1BIT   = 3'd0,
    DEPTH_PAL8   = 3'd1,
    DEPTH_RGB555 = 3'd2,
    DEPTH_RGB24  = 3'd3,
    DEPTH_RGB32  = 3'd4
  } depth_e;

  typedef enum logic [1:0] {
    CFG_DEPTH_MODE   = 2'd0,
    CFG_IMAGE_WIDTH  = 2'd1,
    CFG_IMAGE_HEIGHT = 2'd2,
    CFG_BOTTOM_UP    = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    CMD_PIXEL   = 1'b0,
    CMD_PALETTE = 1'b1
  } cmd_e;

endpackage

@@ rtl/core/bpu_ram.sv @@
// ----------------------------------------------------------------------------
// bpu_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module bpu_ram #(
  parameter int Width = 24,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/bmp_pixel_unpacker_core.sv @@
// ----------------------------------------------------------------------------
// bmp_pixel_unpacker_core
// Unpacks BMP pixel-array bytes into RGB pixels with their raster index.
//
// Input channel: one transaction per byte of the stored pixel array (row
// padding included) with command = pixel, or one palette write with
// command = palette. Output channel: one transaction per decoded pixel.
// Both channels use valid/stall; the config port uses valid/ready and is
// always ready. Write config only while the block is idle.
//
// A byte is registered in the decode stage, reading the palette RAM on the
// way in, then its pixel is registered in the output register. Bytes of
// 8/16/24/32-bit mode and palette writes are taken one per cycle while the
// output is not stalled; in 1-bit mode a byte stays in the decode stage
// until each pixel it produces (up to eight) has left through the single
// output register.
// A stalled output holds its pixel, and the block keeps one byte pending in
// the decode stage before it stalls the input.
// Reset clears the counters and the partial pixel; the palette holds no
// defined contents until written.
// ----------------------------------------------------------------------------
module bmp_pixel_unpacker_core import bpu_pkg::*; #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // config write port
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [DimW-1:0]    cfg_data_i,
  // input channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               command_i,
  input  logic [7:0]         data_byte_i,
  input  logic [7:0]         palette_index_i,
  input  logic [ColorW-1:0]  palette_color_i,
  // output channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         red_o,
  output logic [7:0]         green_o,
  output logic [7:0]         blue_o,
  output logic [IndexW-1:0]  pixel_index_o,
  output logic               last_of_byte_o,
  output logic               image_done_o
);

  localparam int AddrW = $clog2(PALETTE_DEPTH);

  // configuration
  logic [2:0]      depth_mode_q;
  logic [DimW-1:0] image_width_q, image_height_q;
  logic            bottom_up_q;

  // decode state
  logic [23:0]     held_q, held_d;
  logic [1:0]      phase_q, phase_d;
  logic [PosW-1:0] col_q, col_d, row_q, row_d;
  logic [1:0]      rbc_q, rbc_d;
  logic            in_padding_q, in_padding_d;

  // decode stage
  logic            s1_valid_q, s1_first_q, s1_oob_q;
  logic [2:0]      s1_mode_q;
  logic [2:0]      s1_bit_q;
  logic [7:0]      s1_byte_q;

  // output register
  logic              out_valid_q;
  logic [7:0]        red_q, green_q, blue_q;
  logic [IndexW-1:0] index_q;
  logic              last_q, done_q;

  logic              accept, load, pal_we, pal_re;
  logic [ColorW-1:0] pal_rdata;

  logic [DimW-1:0]   w_eff, h_eff;
  logic              out_free, pad, multi, pix_ready, accum, emit, step, last_pix, retire;
  logic [1:0]        rbc_eff;
  logic [PosW-1:0]   col_cur, row_cur, drow;
  logic [DimW-1:0]   col_nx, row_nx;
  logic              row_end, img_done;
  logic [24:0]       prod;
  logic [IndexW-1:0] index_calc;
  logic [7:0]        r_c, g_c, b_c, mono;

  assign cfg_ready_o = 1'b1;

  // ---------------------------------------------------------------------------
  // Input handshake and palette RAM
  // ---------------------------------------------------------------------------
  assign in_stall_o = s1_valid_q && !retire;
  assign accept     = in_valid_i && !in_stall_o;
  assign load       = accept && (command_i == CMD_PIXEL) && (depth_mode_q <= DEPTH_RGB32);
  assign pal_we     = accept && (command_i == CMD_PALETTE)
                      && ({1'b0, palette_index_i} < 9'(PALETTE_DEPTH));
  assign pal_re     = load && (depth_mode_q == DEPTH_PAL8);

  bpu_ram #(
    .Width (ColorW),
    .Depth (PALETTE_DEPTH)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (pal_we),
    .waddr_i (palette_index_i[AddrW-1:0]),
    .wdata_i (palette_color_i),
    .re_i    (pal_re),
    .raddr_i (data_byte_i[AddrW-1:0]),
    .rdata_o (pal_rdata)
  );

  // ---------------------------------------------------------------------------
  // Decode
  // ---------------------------------------------------------------------------
  assign w_eff = (image_width_q == '0) ? DimW'(1)
               : (image_width_q > DimW'(WidthLimit)) ? DimW'(WidthLimit) : image_width_q;
  assign h_eff = (image_height_q == '0) ? DimW'(1)
               : (image_height_q > DimW'(HeightLimit)) ? DimW'(HeightLimit) : image_height_q;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign pad       = s1_first_q && in_padding_q;
  assign multi     = (s1_mode_q == DEPTH_RGB555) || (s1_mode_q == DEPTH_RGB24)
                     || (s1_mode_q == DEPTH_RGB32);
  assign pix_ready = !multi || ((3'({1'b0, phase_q}) + 3'd1) >= s1_mode_q);
  assign accum     = s1_valid_q && !pad && multi && !pix_ready;
  assign emit      = s1_valid_q && !pad && pix_ready && out_free;
  assign step      = s1_valid_q && (pad || accum || emit);
  assign rbc_eff   = s1_first_q ? rbc_q + 2'd1 : rbc_q;

  // restart the position when it lies outside a shrunken image
  always_comb begin
    if ({1'b0, col_q} >= w_eff || {1'b0, row_q} >= h_eff) begin
      col_cur = '0;
      row_cur = '0;
    end else begin
      col_cur = col_q;
      row_cur = row_q;
    end
  end

  assign col_nx   = {1'b0, col_cur} + DimW'(1);
  assign row_nx   = {1'b0, row_cur} + DimW'(1);
  assign row_end  = col_nx >= w_eff;
  assign img_done = row_end && (row_nx >= h_eff);
  assign last_pix = (s1_mode_q != DEPTH_1BIT) || (s1_bit_q == 3'd0) || row_end;
  assign retire   = s1_valid_q && (pad || accum || (emit && last_pix));

  assign drow       = bottom_up_q ? PosW'(h_eff - DimW'(1) - {1'b0, row_cur}) : row_cur;
  assign prod       = 25'(drow) * 25'(w_eff);
  assign index_calc = IndexW'(prod + 25'(col_cur));

  assign mono = s1_byte_q[s1_bit_q] ? 8'hff : 8'h00;

  always_comb begin
    r_c = '0;
    g_c = '0;
    b_c = '0;
    case (s1_mode_q)
      DEPTH_1BIT: begin
        r_c = mono;
        g_c = mono;
        b_c = mono;
      end
      DEPTH_PAL8: begin
        if (!s1_oob_q) begin
          r_c = pal_rdata[23:16];
          g_c = pal_rdata[15:8];
          b_c = pal_rdata[7:0];
        end
      end
      DEPTH_RGB555: begin
        // 5-bit fields, zero-extended
        r_c = {3'b000, s1_byte_q[6:2]};
        g_c = {3'b000, s1_byte_q[1:0], held_q[7:5]};
        b_c = {3'b000, held_q[4:0]};
      end
      DEPTH_RGB24: begin
        r_c = s1_byte_q;
        g_c = held_q[15:8];
        b_c = held_q[7:0];
      end
      DEPTH_RGB32: begin
        r_c = held_q[23:16];
        g_c = held_q[15:8];
        b_c = held_q[7:0];
      end
      default: ;
    endcase
  end

  always_comb begin
    held_d       = held_q;
    phase_d      = phase_q;
    col_d        = col_q;
    row_d        = row_q;
    rbc_d        = rbc_q;
    in_padding_d = in_padding_q;
    if (step) begin
      rbc_d = rbc_eff;
      if (pad) begin
        if (rbc_eff == 2'd0) begin
          in_padding_d = 1'b0;
        end
      end else begin
        col_d = col_cur;
        row_d = row_cur;
        if (accum) begin
          case (phase_q)
            2'd0:    held_d = held_q | {16'h0000, s1_byte_q};
            2'd1:    held_d = held_q | {8'h00, s1_byte_q, 8'h00};
            2'd2:    held_d = held_q | {s1_byte_q, 16'h0000};
            default: held_d = held_q;
          endcase
          phase_d = phase_q + 2'd1;
        end else begin
          phase_d = '0;
          if (multi) begin
            held_d = '0;
          end
          if (row_end) begin
            col_d = '0;
            row_d = img_done ? '0 : row_nx[PosW-1:0];
          end else begin
            col_d = col_nx[PosW-1:0];
          end
          // pad the row once its last pixel leaves an unaligned byte count
          if (last_pix && row_end && rbc_eff != 2'd0) begin
            in_padding_d = 1'b1;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_mode_q   <= DEPTH_RGB24;
      image_width_q  <= DimW'(1);
      image_height_q <= DimW'(1);
      bottom_up_q    <= 1'b1;
      held_q         <= '0;
      phase_q        <= '0;
      col_q          <= '0;
      row_q          <= '0;
      rbc_q          <= '0;
      in_padding_q   <= 1'b0;
      s1_valid_q     <= 1'b0;
      s1_first_q     <= 1'b0;
      s1_oob_q       <= 1'b0;
      s1_mode_q      <= DEPTH_1BIT;
      s1_bit_q       <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_DEPTH_MODE:   depth_mode_q   <= cfg_data_i[2:0];
          CFG_IMAGE_WIDTH:  image_width_q  <= cfg_data_i;
          CFG_IMAGE_HEIGHT: image_height_q <= cfg_data_i;
          CFG_BOTTOM_UP:    bottom_up_q    <= cfg_data_i[0];
          default: ;
        endcase
      end
      held_q       <= held_d;
      phase_q      <= phase_d;
      col_q        <= col_d;
      row_q        <= row_d;
      rbc_q        <= rbc_d;
      in_padding_q <= in_padding_d;

      if (load) begin
        s1_valid_q <= 1'b1;
        s1_first_q <= 1'b1;
        s1_oob_q   <= {1'b0, data_byte_i} >= 9'(PALETTE_DEPTH);
        s1_mode_q  <= depth_mode_q;
        s1_bit_q   <= 3'd7;
      end else begin
        if (retire) begin
          s1_valid_q <= 1'b0;
        end
        if (step) begin
          s1_first_q <= 1'b0;
        end
        if (emit) begin
          s1_bit_q <= s1_bit_q - 3'd1;
        end
      end

      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload: hold the byte in decode and the pixel while stalled
  always_ff @(posedge clk_i) begin
    if (load) begin
      s1_byte_q <= data_byte_i;
    end
    if (emit) begin
      red_q   <= r_c;
      green_q <= g_c;
      blue_q  <= b_c;
      index_q <= index_calc;
      last_q  <= last_pix;
      done_q  <= img_done;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign red_o          = red_q;
  assign green_o        = green_q;
  assign blue_o         = blue_q;
  assign pixel_index_o  = index_q;
  assign last_of_byte_o = last_q;
  assign image_done_o   = done_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_padding_unaligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_padding_q |-> rbc_q != 2'd0)
    else $error("padding active on an aligned row byte count");

  a_multi_cycle_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_first_q |-> s1_mode_q == DEPTH_1BIT)
    else $error("byte stayed in decode past its first pixel outside 1-bit mode");

  a_done_ends_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && img_done |-> retire)
    else $error("image end did not finish the current byte");

endmodule

@@ tb/sv/bpu_pixel_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bpu_pixel_checker
// Watches the config, byte and pixel channels of the BMP pixel unpacker,
// decodes every accepted byte on its own copy of the block state and
// compares each accepted pixel, field by field, with the oldest expected one.
// ----------------------------------------------------------------------------
module bpu_pixel_checker import bpu_pkg::*; #(
  parameter int PaletteDepth = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [DimW-1:0]   cfg_data_i,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic              command_i,
  input  logic [7:0]        data_byte_i,
  input  logic [7:0]        palette_index_i,
  input  logic [ColorW-1:0] palette_color_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic [7:0]        red_i,
  input  logic [7:0]        green_i,
  input  logic [7:0]        blue_i,
  input  logic [IndexW-1:0] pixel_index_i,
  input  logic              last_of_byte_i,
  input  logic              image_done_i,
  output int unsigned       errors_o,
  output int unsigned       pending_o
);

  typedef struct packed {
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic [IndexW-1:0] index;
    logic              last;
    logic              done;
  } pixel_t;

  pixel_t expected_pixels[$];
  pixel_t burst[$];

  logic [2:0]        cfg_depth;
  logic [DimW-1:0]   cfg_width;
  logic [DimW-1:0]   cfg_height;
  logic              cfg_bottom_up;
  int unsigned       eff_w;
  int unsigned       eff_h;

  logic [23:0]       held;
  logic [1:0]        phase;
  logic [PosW-1:0]   col_pos;
  logic [PosW-1:0]   row_pos;
  logic [1:0]        row_bytes;
  logic              in_padding;
  logic [ColorW-1:0] pal_mem [PaletteDepth];

  int unsigned       error_count = 0;
  int unsigned       pixel_count = 0;

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("ERROR %0t: pixel %0d %s: got 0x%0h, want 0x%0h",
             $time, pixel_count, what, got, want);
    error_count++;
  endtask

  task automatic place_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                             output bit row_end);
    int unsigned drow;
    pixel_t px;
    drow = cfg_bottom_up ? eff_h - 1 - row_pos : row_pos;
    px.red = r;
    px.green = g;
    px.blue = b;
    px.index = IndexW'(drow * eff_w + col_pos);
    px.last = 1'b0;
    px.done = 1'b0;
    row_end = 1'b0;
    if (int'(col_pos) + 1 >= eff_w) begin
      col_pos = '0;
      row_end = 1'b1;
      if (int'(row_pos) + 1 >= eff_h) begin
        row_pos = '0;
        px.done = 1'b1;
      end else begin
        row_pos++;
      end
    end else begin
      col_pos++;
    end
    burst.push_back(px);
  endtask

  task automatic decode_byte(cmd_e cmd, logic [7:0] data, logic [7:0] pidx,
                             logic [ColorW-1:0] color);
    bit row_end;
    logic [ColorW-1:0] entry;
    logic [7:0] r, g, b;
    pixel_t px;
    row_end = 1'b0;
    if (cmd == CMD_PALETTE) begin
      if (pidx < PaletteDepth) pal_mem[pidx] = color;
      return;
    end
    if (cfg_depth > DEPTH_RGB32) return;
    eff_w = (cfg_width == 0) ? 1 : ((cfg_width > WidthLimit) ? WidthLimit : cfg_width);
    eff_h = (cfg_height == 0) ? 1 : ((cfg_height > HeightLimit) ? HeightLimit : cfg_height);
    row_bytes = row_bytes + 2'd1;
    if (in_padding) begin
      if (row_bytes == 2'd0) in_padding = 1'b0;
      return;
    end
    // restart when the image shrank under the current position
    if (col_pos >= eff_w || row_pos >= eff_h) begin
      col_pos = '0;
      row_pos = '0;
    end
    case (cfg_depth)
      DEPTH_1BIT: begin
        for (int k = 7; k >= 0 && !row_end; k--) begin
          r = data[k] ? 8'hff : 8'h00;
          place_pixel(r, r, r, row_end);
        end
        phase = '0;
      end
      DEPTH_PAL8: begin
        entry = (data < PaletteDepth) ? pal_mem[data] : '0;
        place_pixel(entry[23:16], entry[15:8], entry[7:0], row_end);
        phase = '0;
      end
      default: begin
        // bytes per pixel equals the depth code for 16, 24 and 32 bit
        if (int'(phase) + 1 >= int'(cfg_depth)) begin
          case (cfg_depth)
            DEPTH_RGB555: begin
              r = {3'b000, data[6:2]};
              g = {3'b000, data[1:0], held[7:5]};
              b = {3'b000, held[4:0]};
            end
            DEPTH_RGB24: begin
              r = data;
              g = held[15:8];
              b = held[7:0];
            end
            default: begin
              r = held[23:16];
              g = held[15:8];
              b = held[7:0];
            end
          endcase
          place_pixel(r, g, b, row_end);
          phase = '0;
          held = '0;
        end else begin
          held = held | (24'(data) << (8 * phase));
          phase = phase + 2'd1;
        end
      end
    endcase
    if (row_end && row_bytes != 2'd0) in_padding = 1'b1;
    foreach (burst[k]) begin
      px = burst[k];
      px.last = (k == burst.size() - 1);
      expected_pixels.push_back(px);
    end
    burst.delete();
  endtask

  task automatic check_pixel();
    pixel_t want;
    if (expected_pixels.size() == 0) begin
      report_mismatch("unexpected, index", pixel_index_i, '0);
    end else begin
      want = expected_pixels.pop_front();
      if (red_i !== want.red) report_mismatch("red", red_i, want.red);
      if (green_i !== want.green) report_mismatch("green", green_i, want.green);
      if (blue_i !== want.blue) report_mismatch("blue", blue_i, want.blue);
      if (pixel_index_i !== want.index) report_mismatch("pixel_index", pixel_index_i, want.index);
      if (last_of_byte_i !== want.last) report_mismatch("last_of_byte", last_of_byte_i, want.last);
      if (image_done_i !== want.done) report_mismatch("image_done", image_done_i, want.done);
    end
    pixel_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_depth = DEPTH_RGB24;
      cfg_width = DimW'(1);
      cfg_height = DimW'(1);
      cfg_bottom_up = 1'b1;
      held = '0;
      phase = '0;
      col_pos = '0;
      row_pos = '0;
      row_bytes = '0;
      in_padding = 1'b0;
      expected_pixels.delete();
      pending_o <= 0;
      errors_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_DEPTH_MODE:   cfg_depth = cfg_data_i[2:0];
          CFG_IMAGE_WIDTH:  cfg_width = cfg_data_i;
          CFG_IMAGE_HEIGHT: cfg_height = cfg_data_i;
          CFG_BOTTOM_UP:    cfg_bottom_up = cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        decode_byte(cmd_e'(command_i), data_byte_i, palette_index_i, palette_color_i);
      end
      if (out_valid_i && !out_stall_i) check_pixel();
      pending_o <= expected_pixels.size();
      errors_o <= error_count;
    end
  end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Streams BMP pixel-array bytes and palette writes into the unpacker over a
// series of depth, size and row-order settings: a directed opening, a
// back-pressure phase, then random images, mostly whole and some cut short.
// Both channels idle at random; the checker judges every pixel.
// ----------------------------------------------------------------------------
module testbench;
  import bpu_pkg::*;

  localparam int ClkPeriod = 10;
  localparam int CycleLimit = 600000;
  localparam int ItemTarget = 220;
  localparam int LongHold = 150;
  localparam int SettleCycles = 12;
  localparam logic [2:0] DepthUnusedLo = 3'd5;
  localparam logic [2:0] DepthUnusedHi = 3'd7;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [1:0]        cfg_index = CFG_DEPTH_MODE;
  logic [DimW-1:0]   cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              command = CMD_PIXEL;
  logic [7:0]        data_byte = '0;
  logic [7:0]        palette_index = '0;
  logic [ColorW-1:0] palette_color = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [7:0]        red, green, blue;
  logic [IndexW-1:0] pixel_index;
  logic              last_of_byte;
  logic              image_done;
  int unsigned       errors;
  int unsigned       pending;

  bit                in_quiet = 1'b0;
  bit                out_quiet = 1'b0;
  int                hold_asks = 0;
  int                holds_done = 0;
  int unsigned       cycle_count = 0;
  int                items_sent = 0;
  logic [2:0]        depth_now = DEPTH_RGB24;
  int                width_now = 1;
  int                height_now = 1;
  bit                pal_known [256];
  logic [7:0]        pal_used[$];

  bmp_pixel_unpacker_core u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .command_i       (command),
    .data_byte_i     (data_byte),
    .palette_index_i (palette_index),
    .palette_color_i (palette_color),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .red_o           (red),
    .green_o         (green),
    .blue_o          (blue),
    .pixel_index_o   (pixel_index),
    .last_of_byte_o  (last_of_byte),
    .image_done_o    (image_done)
  );

  bpu_pixel_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .command_i       (command),
    .data_byte_i     (data_byte),
    .palette_index_i (palette_index),
    .palette_color_i (palette_color),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .red_i           (red),
    .green_i         (green),
    .blue_i          (blue),
    .pixel_index_i   (pixel_index),
    .last_of_byte_i  (last_of_byte),
    .image_done_i    (image_done),
    .errors_o        (errors),
    .pending_o       (pending)
  );

  always #(ClkPeriod / 2) clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // mostly short idles, a few long ones, none in quiet phases
  function automatic int pick_gap(bit quiet);
    int roll;
    if (quiet) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [DimW-1:0] pick_dim(int typical_max);
    if ($urandom_range(0, 9) != 0) return DimW'($urandom_range(1, typical_max));
    case ($urandom_range(0, 3))
      0: return '0;
      1: return DimW'(4095);
      2: return DimW'(4096);
      default: return '1;
    endcase
  endfunction

  // receiver side: random stalls, plus a long hold on request
  initial begin : out_side
    int span;
    @(posedge clk);
    forever begin
      if (holds_done != hold_asks) begin
        out_stall <= 1'b1;
        repeat (LongHold) @(posedge clk);
        holds_done++;
      end else begin
        span = pick_gap(out_quiet);
        if (span != 0) begin
          out_stall <= 1'b1;
          repeat (span) @(posedge clk);
        end
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  task automatic send_item(cmd_e cmd, logic [7:0] data, logic [7:0] pidx,
                           logic [ColorW-1:0] color);
    int gap;
    gap = pick_gap(in_quiet);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    data_byte <= data;
    palette_index <= pidx;
    palette_color <= color;
    do @(posedge clk); while (in_stall);
    if (cmd == CMD_PALETTE && !pal_known[pidx]) begin
      pal_known[pidx] = 1'b1;
      pal_used.push_back(pidx);
    end
    if (cmd == CMD_PALETTE || depth_now <= DEPTH_RGB32) items_sent++;
  endtask

  // hold input until every expected pixel is out and the pipe has settled
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [DimW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_image(logic [2:0] depth, logic [DimW-1:0] w, logic [DimW-1:0] h,
                               logic bottom_up);
    drain();
    write_reg(CFG_DEPTH_MODE, DimW'(depth));
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_IMAGE_HEIGHT, h);
    write_reg(CFG_BOTTOM_UP, DimW'(bottom_up));
    depth_now = depth;
    width_now = (w == 0) ? 1 : ((w > WidthLimit) ? WidthLimit : w);
    height_now = (h == 0) ? 1 : ((h > HeightLimit) ? HeightLimit : h);
  endtask

  // stream the stored pixel array of the current setting, padding included
  task automatic send_image(int byte_limit);
    int row_len;
    int total;
    logic [7:0] data;
    case (depth_now)
      DEPTH_1BIT:   row_len = (width_now + 7) / 8;
      DEPTH_PAL8:   row_len = width_now;
      DEPTH_RGB555: row_len = 2 * width_now;
      DEPTH_RGB24:  row_len = 3 * width_now;
      DEPTH_RGB32:  row_len = 4 * width_now;
      default:      row_len = 4;
    endcase
    row_len = (row_len + 3) / 4 * 4;
    total = row_len * height_now;
    if (total > byte_limit) total = byte_limit;
    for (int k = 0; k < total; k++) begin
      if ($urandom_range(0, 15) == 0) begin
        send_item(CMD_PALETTE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  ColorW'($urandom));
      end
      // palette mode reads only entries that were written
      if (depth_now == DEPTH_PAL8) data = pal_used[$urandom_range(0, pal_used.size() - 1)];
      else data = 8'($urandom_range(0, 255));
      send_item(CMD_PIXEL, data, 8'($urandom_range(0, 255)), ColorW'($urandom));
    end
  endtask

  initial begin : stimulus
    logic [2:0] depth;
    logic [DimW-1:0] w, h;
    int budget;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset setting: 24-bit, 1x1, bottom-up; one pixel then one pad byte
    send_item(CMD_PIXEL, 8'h00, 8'h00, '0);
    send_item(CMD_PIXEL, 8'hff, 8'hff, '1);
    send_item(CMD_PIXEL, 8'h80, 8'h00, '0);
    send_item(CMD_PIXEL, 8'hff, 8'hff, '1);

    // oversized dimensions saturate; indexes start in the highest row
    program_image(DEPTH_1BIT, '1, '1, 1'b1);
    send_item(CMD_PIXEL, 8'h80, 8'h00, '0);
    send_item(CMD_PIXEL, 8'h01, 8'h00, '0);
    send_item(CMD_PIXEL, 8'hff, 8'h00, '0);
    send_item(CMD_PIXEL, 8'h00, 8'h00, '0);

    // unused depth codes drop data bytes
    program_image(DepthUnusedHi, DimW'(2), DimW'(2), 1'b0);
    send_item(CMD_PIXEL, 8'h5a, 8'h00, '0);
    send_item(CMD_PIXEL, 8'ha5, 8'h00, '0);
    send_item(CMD_PALETTE, 8'h00, 8'h00, 24'h000000);
    send_item(CMD_PALETTE, 8'h00, 8'hff, 24'hffffff);
    send_item(CMD_PALETTE, 8'h00, 8'h5a, 24'h80ff01);

    // shrunken image: the old position restarts at zero
    program_image(DEPTH_PAL8, DimW'(3), DimW'(2), 1'b0);
    send_item(CMD_PIXEL, 8'hff, 8'h00, '0);
    send_item(CMD_PIXEL, 8'h00, 8'h00, '0);
    send_item(CMD_PIXEL, 8'h5a, 8'h00, '0);
    send_item(CMD_PIXEL, 8'h00, 8'h00, '0);

    // zero width saturates to one; 5-5-5 components stay unscaled
    program_image(DEPTH_RGB555, '0, DimW'(1), 1'b1);
    send_item(CMD_PIXEL, 8'hff, 8'h00, '0);
    send_item(CMD_PIXEL, 8'hff, 8'h00, '0);
    send_item(CMD_PIXEL, 8'h00, 8'h00, '0);
    send_item(CMD_PIXEL, 8'h00, 8'h00, '0);

    program_image(DEPTH_RGB32, DimW'(1), DimW'(1), 1'b0);
    send_item(CMD_PIXEL, 8'h01, 8'h00, '0);
    send_item(CMD_PIXEL, 8'h02, 8'h00, '0);
    send_item(CMD_PIXEL, 8'h03, 8'h00, '0);
    send_item(CMD_PIXEL, 8'h04, 8'h00, '0);

    // back-pressure: hold the output while bytes keep coming
    program_image(DEPTH_1BIT, DimW'(32), DimW'(4), 1'b0);
    in_quiet = 1'b1;
    hold_asks++;
    send_image(64);
    in_quiet = 1'b0;

    while (items_sent < ItemTarget) begin
      if ($urandom_range(0, 24) == 0) depth = 3'($urandom_range(DepthUnusedLo, DepthUnusedHi));
      else depth = 3'($urandom_range(DEPTH_1BIT, DEPTH_RGB32));
      w = pick_dim(6);
      h = pick_dim(3);
      in_quiet = ($urandom_range(0, 5) == 0);
      out_quiet = ($urandom_range(0, 5) == 0);
      program_image(depth, w, h, 1'($urandom_range(0, 1)));
      // cut some images short so the next setting starts mid-image
      budget = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 12) : 96;
      if (budget > ItemTarget - items_sent) budget = ItemTarget - items_sent;
      send_image(budget);
    end

    drain();
    if (errors == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/bpu_pkg.sv
rtl/core/bpu_ram.sv
rtl/core/bmp_pixel_unpacker_core.sv
tb/sv/bpu_pixel_checker.sv
tb/sv/testbench.sv
